// ===== src/one_wire_bus_master_unit_assert.svh =====
// Assertion macros shared by the one-wire bus master RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ONE_WIRE_BUS_MASTER_UNIT_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define OWBM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequence must hold in the cycle after the condition.
`define OWBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/owbm_pkg.sv =====
// Types and constants of the one-wire bus master.
// Used by owbm_seq and one_wire_bus_master_unit; depends on nothing else.
package owbm_pkg;

  // Configuration register file: eight timing values of ten bits each.
  localparam int unsigned CFG_COUNT      = 8;
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 10;

  typedef logic [CFG_DATA_BITS-1:0] cfg_word_t;
  typedef cfg_word_t [CFG_COUNT-1:0] cfg_regs_t;

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_RESET_LOW   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PRES_SAMPLE = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RESET_REC   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_W1_LOW      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_W1_HIGH     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_W0_LOW      = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RD_LOW      = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RD_SAMPLE   = 3'd7;

  // Register values after reset, from the highest index down to index zero.
  localparam cfg_regs_t CFG_RESET_VALS = '{
    10'd10,  // read sample
    10'd3,   // read low
    10'd65,  // write-zero low
    10'd55,  // write-one high
    10'd10,  // write-one low
    10'd490, // reset recovery
    10'd65,  // presence sample
    10'd500  // reset low
  };

  // Fixed slot times in microseconds.
  localparam cfg_word_t WRITE_ZERO_RECOVERY = 10'd5;
  localparam cfg_word_t READ_TAIL_TIME      = 10'd53;

  // Operation codes of an input transaction.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Bus sequencer phases, one-hot.
  typedef enum logic [9:0] {
    PH_IDLE   = 10'b00_0000_0001,
    PH_RWAIT  = 10'b00_0000_0010,
    PH_RLOW   = 10'b00_0000_0100,
    PH_RREL   = 10'b00_0000_1000,
    PH_RREC   = 10'b00_0001_0000,
    PH_WLOW   = 10'b00_0010_0000,
    PH_WHIGH  = 10'b00_0100_0000,
    PH_RDLOW  = 10'b00_1000_0000,
    PH_RDREL  = 10'b01_0000_0000,
    PH_RDTAIL = 10'b10_0000_0000
  } phase_t;

  // Result of one transaction.
  typedef struct packed {
    logic       pull_low;
    logic       busy;
    logic       done;
    logic [7:0] read_data;
    logic       presence;
    logic       rejected;
  } res_t;

endpackage

// ===== src/owbm_seq.sv =====
// Bus sequencer of the one-wire bus master: phase, slot timer, bit and byte state.
// Depends on owbm_pkg for phases, operation codes, register layout and result type.
module owbm_seq #(
  parameter int unsigned TIMER_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  owbm_pkg::op_t      step_op,
  input  logic [7:0]         step_data,
  input  logic               step_lvl,
  input  owbm_pkg::cfg_regs_t regs,
  output owbm_pkg::res_t     res
);

  localparam int unsigned TB = TIMER_BITS;

  owbm_pkg::phase_t phase_r, phase_nxt;
  logic [TB-1:0]    timer_r, timer_nxt;
  logic [2:0]       bit_idx_r, bit_idx_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [7:0]       read_byte_r, read_byte_nxt;
  logic             presence_r, presence_nxt;
  logic             drive_low_r, drive_low_nxt;
  logic             done, rejected;

  logic [TB-1:0]    tdec, whigh_t, tail_t, rec_t;
  logic [2:0]       idx_inc;
  logic             last_bit, cur_bit;
  logic [7:0]       rd_shift;

  // Slot time masked to the timer width, optionally forced to at least one.
  function automatic logic [TB-1:0] dur_f(input owbm_pkg::cfg_word_t v, input logic min1);
    logic [TB-1:0] t;
    t = TB'(v);
    if (min1 && (t == '0)) begin
      t = TB'(1);
    end
    return t;
  endfunction

  // Low time of a write slot for the given bit value.
  function automatic logic [TB-1:0] wlow_f(input logic b, input owbm_pkg::cfg_regs_t r);
    return dur_f(b ? r[owbm_pkg::REG_W1_LOW] : r[owbm_pkg::REG_W0_LOW], 1'b1);
  endfunction

  // Values shared by several phase transitions.
  always_comb begin
    tdec     = (timer_r != '0) ? (timer_r - TB'(1)) : '0;
    idx_inc  = bit_idx_r + 3'd1;
    last_bit = (bit_idx_r == 3'd7);
    cur_bit  = shift_r[bit_idx_r];
    whigh_t  = cur_bit ? dur_f(regs[owbm_pkg::REG_W1_HIGH], 1'b0)
                       : dur_f(owbm_pkg::WRITE_ZERO_RECOVERY, 1'b0);
    tail_t   = dur_f(owbm_pkg::READ_TAIL_TIME, 1'b0);
    rec_t    = dur_f(regs[owbm_pkg::REG_RESET_REC], 1'b0);
    rd_shift = shift_r;
    rd_shift[bit_idx_r] = shift_r[bit_idx_r] | step_lvl;
  end

  // Next state for one transaction. Zero-length released, recovery and tail
  // phases are folded into the transition that would enter them.
  always_comb begin
    phase_nxt     = phase_r;
    timer_nxt     = timer_r;
    bit_idx_nxt   = bit_idx_r;
    shift_nxt     = shift_r;
    read_byte_nxt = read_byte_r;
    presence_nxt  = presence_r;
    drive_low_nxt = drive_low_r;
    done          = 1'b0;
    rejected      = 1'b0;
    if (step_en) begin
      if (step_op != owbm_pkg::OP_TICK) begin
        if (phase_r != owbm_pkg::PH_IDLE) begin
          rejected = 1'b1;
        end else begin
          case (step_op)
            owbm_pkg::OP_RESET: begin
              phase_nxt     = owbm_pkg::PH_RWAIT;
              drive_low_nxt = 1'b0;
              timer_nxt     = '0;
            end
            owbm_pkg::OP_WRITE: begin
              shift_nxt     = step_data;
              bit_idx_nxt   = 3'd0;
              phase_nxt     = owbm_pkg::PH_WLOW;
              drive_low_nxt = 1'b1;
              timer_nxt     = wlow_f(step_data[0], regs);
            end
            owbm_pkg::OP_READ: begin
              shift_nxt     = 8'd0;
              bit_idx_nxt   = 3'd0;
              phase_nxt     = owbm_pkg::PH_RDLOW;
              drive_low_nxt = 1'b1;
              timer_nxt     = dur_f(regs[owbm_pkg::REG_RD_LOW], 1'b1);
            end
            default: begin
            end
          endcase
        end
      end else begin
        case (phase_r)
          owbm_pkg::PH_IDLE: begin
          end
          owbm_pkg::PH_RWAIT: begin
            if (step_lvl) begin
              phase_nxt     = owbm_pkg::PH_RLOW;
              drive_low_nxt = 1'b1;
              timer_nxt     = dur_f(regs[owbm_pkg::REG_RESET_LOW], 1'b1);
            end
          end
          default: begin
            if (tdec != '0) begin
              timer_nxt = tdec;
            end else begin
              // The current timed phase ends on this tick.
              drive_low_nxt = 1'b0;
              timer_nxt     = '0;
              case (phase_r)
                owbm_pkg::PH_RLOW: begin
                  phase_nxt = owbm_pkg::PH_RREL;
                  timer_nxt = dur_f(regs[owbm_pkg::REG_PRES_SAMPLE], 1'b1);
                end
                owbm_pkg::PH_RREL: begin
                  presence_nxt = step_lvl;
                  if (rec_t == '0) begin
                    phase_nxt = owbm_pkg::PH_IDLE;
                    done      = 1'b1;
                  end else begin
                    phase_nxt = owbm_pkg::PH_RREC;
                    timer_nxt = rec_t;
                  end
                end
                owbm_pkg::PH_RREC: begin
                  phase_nxt = owbm_pkg::PH_IDLE;
                  done      = 1'b1;
                end
                owbm_pkg::PH_WLOW: begin
                  if (whigh_t != '0) begin
                    phase_nxt = owbm_pkg::PH_WHIGH;
                    timer_nxt = whigh_t;
                  end else if (last_bit) begin
                    phase_nxt = owbm_pkg::PH_IDLE;
                    done      = 1'b1;
                  end else begin
                    bit_idx_nxt   = idx_inc;
                    phase_nxt     = owbm_pkg::PH_WLOW;
                    drive_low_nxt = 1'b1;
                    timer_nxt     = wlow_f(shift_r[idx_inc], regs);
                  end
                end
                owbm_pkg::PH_WHIGH: begin
                  if (last_bit) begin
                    phase_nxt = owbm_pkg::PH_IDLE;
                    done      = 1'b1;
                  end else begin
                    bit_idx_nxt   = idx_inc;
                    phase_nxt     = owbm_pkg::PH_WLOW;
                    drive_low_nxt = 1'b1;
                    timer_nxt     = wlow_f(shift_r[idx_inc], regs);
                  end
                end
                owbm_pkg::PH_RDLOW: begin
                  phase_nxt = owbm_pkg::PH_RDREL;
                  timer_nxt = dur_f(regs[owbm_pkg::REG_RD_SAMPLE], 1'b1);
                end
                owbm_pkg::PH_RDREL: begin
                  shift_nxt = rd_shift;
                  if (tail_t != '0) begin
                    phase_nxt = owbm_pkg::PH_RDTAIL;
                    timer_nxt = tail_t;
                  end else if (last_bit) begin
                    read_byte_nxt = rd_shift;
                    phase_nxt     = owbm_pkg::PH_IDLE;
                    done          = 1'b1;
                  end else begin
                    bit_idx_nxt   = idx_inc;
                    phase_nxt     = owbm_pkg::PH_RDLOW;
                    drive_low_nxt = 1'b1;
                    timer_nxt     = dur_f(regs[owbm_pkg::REG_RD_LOW], 1'b1);
                  end
                end
                owbm_pkg::PH_RDTAIL: begin
                  if (last_bit) begin
                    read_byte_nxt = shift_r;
                    phase_nxt     = owbm_pkg::PH_IDLE;
                    done          = 1'b1;
                  end else begin
                    bit_idx_nxt   = idx_inc;
                    phase_nxt     = owbm_pkg::PH_RDLOW;
                    drive_low_nxt = 1'b1;
                    timer_nxt     = dur_f(regs[owbm_pkg::REG_RD_LOW], 1'b1);
                  end
                end
                default: begin
                  phase_nxt = owbm_pkg::PH_IDLE;
                end
              endcase
            end
          end
        endcase
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= owbm_pkg::PH_IDLE;
      timer_r     <= '0;
      bit_idx_r   <= 3'd0;
      shift_r     <= 8'd0;
      read_byte_r <= 8'd0;
      presence_r  <= 1'b1;
      drive_low_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      timer_r     <= timer_nxt;
      bit_idx_r   <= bit_idx_nxt;
      shift_r     <= shift_nxt;
      read_byte_r <= read_byte_nxt;
      presence_r  <= presence_nxt;
      drive_low_r <= drive_low_nxt;
    end
  end

  // Result reflects the state after this transaction.
  always_comb begin
    res.pull_low  = drive_low_nxt;
    res.busy      = (phase_nxt != owbm_pkg::PH_IDLE);
    res.done      = done;
    res.read_data = read_byte_nxt;
    res.presence  = presence_nxt;
    res.rejected  = rejected;
  end

endmodule

// ===== src/one_wire_bus_master_unit.sv =====
// Top level of the one-wire bus master: input register, configuration registers,
// result register. Depends on owbm_pkg, owbm_seq and one_wire_bus_master_unit_assert.svh.
//
// One-wire bus master. Each input transaction is either a one-microsecond tick
// carrying the sampled bus level or a command (reset with presence detect, write
// byte, read byte); each gives exactly one result showing whether to pull the bus
// low for the next microsecond, plus busy, done, read byte, presence sample and a
// rejected flag for commands arriving while busy. Slot timing comes from eight
// ten-bit registers written through the cfg_ port; the user must write them only
// while the block is idle, which the block itself does not enforce. The block takes
// one transaction per clock while the result side does not stall: a transaction is
// held in the input register while the sequencer updates its state; its result is
// loaded into the result register as the input register moves on, raising out_valid.
// Stalls on the result side back up into the input register and then into in_stall.
`include "one_wire_bus_master_unit_assert.svh"

module one_wire_bus_master_unit #(
  parameter int unsigned TIMER_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_operation,
  input  logic [7:0]                          in_write_data,
  input  logic                                in_line_level,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_pull_low,
  output logic                                out_busy_res,
  output logic                                out_done_res,
  output logic [7:0]                          out_read_data,
  output logic                                out_presence_level,
  output logic                                out_command_rejected,
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [owbm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [owbm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  logic                s1_valid_r;
  owbm_pkg::op_t       s1_op_r;
  logic [7:0]          s1_data_r;
  logic                s1_lvl_r;
  logic                out_valid_r;
  owbm_pkg::res_t      out_res_r;
  owbm_pkg::res_t      seq_res;
  owbm_pkg::cfg_regs_t cfg_regs_r;
  logic                advance;
  logic                in_take;

  // Pipeline flow: the input register moves on when the result register is free.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= owbm_pkg::op_t'(in_operation);
      s1_data_r <= in_write_data;
      s1_lvl_r  <= in_line_level;
    end
  end

  // Configuration registers; every write transaction is taken at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_regs_r <= owbm_pkg::CFG_RESET_VALS;
    end else if (cfg_valid && cfg_ready) begin
      cfg_regs_r[cfg_index] <= cfg_data;
    end
  end

  // Bus sequencer.
  owbm_seq #(
    .TIMER_BITS (TIMER_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .step_op   (s1_op_r),
    .step_data (s1_data_r),
    .step_lvl  (s1_lvl_r),
    .regs      (cfg_regs_r),
    .res       (seq_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= seq_res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_pull_low         = out_res_r.pull_low;
  assign out_busy_res         = out_res_r.busy;
  assign out_done_res         = out_res_r.done;
  assign out_read_data        = out_res_r.read_data;
  assign out_presence_level   = out_res_r.presence;
  assign out_command_rejected = out_res_r.rejected;

  // A finished sequence leaves the bus idle.
  `OWBM_ASSERT_SAME(a_done_idle, out_valid_r && out_res_r.done, !out_res_r.busy, "done while busy")
  // A rejected command never completes anything and only happens while busy.
  `OWBM_ASSERT_SAME(a_reject_busy, out_valid_r && out_res_r.rejected, out_res_r.busy && !out_res_r.done, "bad reject")
  // The bus is only driven low inside a sequence.
  `OWBM_ASSERT_SAME(a_pull_busy, out_valid_r && out_res_r.pull_low, out_res_r.busy, "pull low while idle")
  // A transaction blocked in the input register is not lost.
  `OWBM_ASSERT_NEXT(a_s1_hold, s1_valid_r && !advance, s1_valid_r, "input transaction dropped")

endmodule
